@@ rtl/core/ild_pkg.sv @@
// Shared types, constants and tree tables for the implode LZ tree decoder.
// Depends on nothing; every other file of the block refers to it by scoped names.
package ild_pkg;

  localparam int WINDOW_DEPTH = 8192;
  localparam int HIST_AW      = $clog2(WINDOW_DEPTH);
  localparam int OUT_LANES    = 8;
  localparam int LANE_CW      = $clog2(OUT_LANES + 1);
  localparam int PROD_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int NUM_TREES    = 7;
  localparam int MAX_CODE     = 16;
  localparam int MATCH_W      = 9;

  // Configuration register indexes
  localparam logic CFG_TEXT_MODE = 1'b0;
  localparam logic CFG_BIG_FILE  = 1'b1;

  localparam logic [5:0] LEN_ESCAPE = 6'd63;

  typedef enum logic [2:0] {
    TREE_LIT,
    TREE_LEN_BIN,
    TREE_DIST_BIN,
    TREE_LEN_TXT_BIG,
    TREE_DIST_TXT_BIG,
    TREE_LEN_TXT_SMALL,
    TREE_DIST_TXT_SMALL
  } tree_id_t;

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_LIT_RAW,
    PH_LIT_TREE,
    PH_LO_DIST,
    PH_HI_DIST,
    PH_LEN,
    PH_LEN_EXT
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_CP_RD,
    S_PUSH,
    S_END
  } seq_t;

  // Canonical view of one tree: per code length the first code (left aligned and
  // shifted down to the length), the number of codes and the first slot of the
  // symbol list; the list holds symbols in code order.
  typedef struct packed {
    logic [MAX_CODE:0][15:0] base;
    logic [MAX_CODE:0][8:0]  cnt;
    logic [MAX_CODE:0][8:0]  start;
    logic [255:0][7:0]       order;
  } tree_info_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] symbol;
  } tree_res_t;

  // Group count, then (run-1)<<4 | (bits-1) per group
  localparam logic [7:0] DESC_DIST_BIN [8] = '{
    8'h07, 8'h01, 8'h13, 8'h34, 8'hE5, 8'hF6, 8'h96, 8'hF7};
  localparam logic [7:0] DESC_LEN_BIN [17] = '{
    8'h10, 8'h00, 8'h12, 8'h03, 8'h24, 8'h15, 8'h36, 8'h27,
    8'h38, 8'h39, 8'h6A, 8'h7B, 8'h4C, 8'h9D, 8'h6E, 8'h1F, 8'h09};
  localparam logic [7:0] DESC_DIST_TXT_BIG [8] = '{
    8'h07, 8'h12, 8'h23, 8'h14, 8'hE5, 8'hF6, 8'h96, 8'hF7};
  localparam logic [7:0] DESC_LEN_TXT_BIG [14] = '{
    8'h0D, 8'h01, 8'h22, 8'h23, 8'h14, 8'h15, 8'h36, 8'h37,
    8'h68, 8'h89, 8'h9A, 8'hDB, 8'h3C, 8'h05};
  localparam logic [7:0] DESC_DIST_TXT_SMALL [8] = '{
    8'h07, 8'h12, 8'h13, 8'h44, 8'hC5, 8'hF6, 8'h96, 8'hF7};
  localparam logic [7:0] DESC_LEN_TXT_SMALL [15] = '{
    8'h0E, 8'h02, 8'h01, 8'h12, 8'h23, 8'h14, 8'h15, 8'h36,
    8'h37, 8'h68, 8'h89, 8'h9A, 8'hDB, 8'h3C, 8'h05};
  localparam logic [7:0] DESC_LIT [99] = '{
    8'h62,
    8'h0A, 8'h7B, 8'h07, 8'h06, 8'h1B, 8'h06, 8'hBB, 8'h0C, 8'h4B, 8'h03, 8'h09, 8'h07,
    8'h0B, 8'h09,
    8'h0B, 8'h09, 8'h07, 8'h16, 8'h07, 8'h08, 8'h06, 8'h05, 8'h06, 8'h07, 8'h06, 8'h05,
    8'h36, 8'h07,
    8'h16, 8'h17, 8'h0B, 8'h0A, 8'h06, 8'h08, 8'h0A, 8'h0B, 8'h05, 8'h06, 8'h15, 8'h04,
    8'h06, 8'h17,
    8'h05, 8'h0A, 8'h08, 8'h05, 8'h06, 8'h15, 8'h06, 8'h0A, 8'h25, 8'h06, 8'h08, 8'h07,
    8'h18, 8'h0A,
    8'h07, 8'h0A, 8'h08, 8'h0B, 8'h07, 8'h0B, 8'h04, 8'h25, 8'h04, 8'h25, 8'h04, 8'h0A,
    8'h06, 8'h04,
    8'h05, 8'h14, 8'h05, 8'h09, 8'h34, 8'h07, 8'h06, 8'h17, 8'h09, 8'h1A, 8'h2B, 8'hFC,
    8'hFC, 8'hFC,
    8'hFB, 8'hFB, 8'hFB, 8'h0C, 8'h0B, 8'h2C, 8'h0B, 8'h2C, 8'h0B, 8'h3C, 8'h0B, 8'h2C,
    8'h2B, 8'hAC};

  function automatic int desc_byte(tree_id_t t, int i);
    int r;
    r = 0;
    case (t)
      TREE_LIT:            if (i < 99) r = int'(DESC_LIT[i]);
      TREE_LEN_BIN:        if (i < 17) r = int'(DESC_LEN_BIN[i]);
      TREE_DIST_BIN:       if (i < 8)  r = int'(DESC_DIST_BIN[i]);
      TREE_LEN_TXT_BIG:    if (i < 14) r = int'(DESC_LEN_TXT_BIG[i]);
      TREE_DIST_TXT_BIG:   if (i < 8)  r = int'(DESC_DIST_TXT_BIG[i]);
      TREE_LEN_TXT_SMALL:  if (i < 15) r = int'(DESC_LEN_TXT_SMALL[i]);
      TREE_DIST_TXT_SMALL: if (i < 8)  r = int'(DESC_DIST_TXT_SMALL[i]);
      default:             r = 0;
    endcase
    return r;
  endfunction

  // Expand a description: longest codes first, highest symbol first in a length.
  function automatic tree_info_t build_tree(tree_id_t t);
    tree_info_t info;
    int lens [256];
    int groups, idx, b, k, code, inc, last, pos, bits, v, g, i;
    info   = '0;
    idx    = 0;
    for (i = 0; i < 256; i++) lens[i] = 0;
    groups = desc_byte(t, 0);
    for (g = 0; g < groups; g++) begin
      b = desc_byte(t, 1 + g);
      for (k = 0; k <= (b >> 4); k++) begin
        if (idx < 256) begin
          lens[idx] = (b & 15) + 1;
          idx++;
        end
      end
    end
    code = 0;
    inc  = 0;
    last = 0;
    pos  = 0;
    for (bits = MAX_CODE; bits >= 1; bits--) begin
      for (v = idx - 1; v >= 0; v--) begin
        if (lens[v] == bits) begin
          code = code + inc;
          if (info.cnt[bits] == 9'd0) begin
            info.base[bits]  = 16'((code & 65535) >> (MAX_CODE - bits));
            info.start[bits] = 9'(pos);
          end
          info.cnt[bits] = info.cnt[bits] + 9'd1;
          info.order[pos] = 8'(v);
          pos++;
          if (bits != last) begin
            last = bits;
            inc  = 1 << (MAX_CODE - bits);
          end
        end
      end
    end
    return info;
  endfunction

  localparam tree_info_t TREE_INFO [NUM_TREES] = '{
    build_tree(TREE_LIT),
    build_tree(TREE_LEN_BIN),
    build_tree(TREE_DIST_BIN),
    build_tree(TREE_LEN_TXT_BIG),
    build_tree(TREE_DIST_TXT_BIG),
    build_tree(TREE_LEN_TXT_SMALL),
    build_tree(TREE_DIST_TXT_SMALL)};

endpackage

@@ rtl/core/ild_channels.sv @@
// Valid/ready channel interfaces for packed input bytes and decoded output beats.
// Depends on ild_pkg for the lane count width.
interface ild_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       final_byte;

  modport source(output valid, packed_byte, final_byte, input ready);
  modport sink(input valid, packed_byte, final_byte, output ready);
endinterface

interface ild_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    lane_0;
  logic [7:0]                    lane_1;
  logic [7:0]                    lane_2;
  logic [7:0]                    lane_3;
  logic [7:0]                    lane_4;
  logic [7:0]                    lane_5;
  logic [7:0]                    lane_6;
  logic [7:0]                    lane_7;
  logic [ild_pkg::LANE_CW-1:0]   valid_count;
  logic                          run_end;
  logic                          stream_done;
  logic                          decode_error;

  modport source(output valid, lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6,
                 lane_7, valid_count, run_end, stream_done, decode_error, input ready);
  modport sink(input valid, lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6,
               lane_7, valid_count, run_end, stream_done, decode_error, output ready);
endinterface

@@ rtl/core/ild_tree_rom.sv @@
// Shared canonical tree lookup: one range compare and subtract per decoded bit.
// Depends on ild_pkg for the tree tables.
module ild_tree_rom (
  input  ild_pkg::tree_id_t tree_sel,
  input  logic [15:0]       code,
  input  logic [4:0]        code_len,
  output ild_pkg::tree_res_t res
);

  ild_pkg::tree_info_t info;
  logic [15:0] base;
  logic [8:0]  cnt;
  logic [15:0] diff;
  logic        match;
  logic [7:0]  slot;

  assign info  = ild_pkg::TREE_INFO[tree_sel];
  assign base  = info.base[code_len];
  assign cnt   = info.cnt[code_len];
  assign diff  = code - base;
  assign match = (cnt != 9'd0) && (code >= base) && (diff < {7'd0, cnt});
  assign slot  = 8'(info.start[code_len] + diff[8:0]);

  always_comb begin
    res.hit    = 1'b0;
    res.symbol = 8'd0;
    if (match) begin
      res.hit    = 1'b1;
      res.symbol = info.order[slot];
    end else if (code_len == 5'(ild_pkg::MAX_CODE)) begin
      // code ran to full length without a match: take symbol zero
      res.hit = 1'b1;
    end
  end

endmodule

@@ rtl/core/ild_history.sv @@
// History window RAM: one write port and one registered read port.
// Depends on ild_pkg for the window depth.
module ild_history (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ild_pkg::HIST_AW-1:0] waddr,
  input  logic [7:0]                  wdata,
  input  logic                        re,
  input  logic [ild_pkg::HIST_AW-1:0] raddr,
  output logic [7:0]                  rdata
);

  logic [7:0] mem [ild_pkg::WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/implode_lz_tree_decoder_top.sv @@
// Top level of the implode LZ tree decoder: sequencer, bit unpacking and lane packing.
// Depends on ild_pkg, ild_channels, ild_tree_rom and ild_history.
//
// Usage:
//   in_chan carries one packed byte per beat with final_byte marking the last one.
//   Bits are consumed least significant first, one bit per cycle while the sequencer
//   is in its bit state, through a single shared tree lookup. A literal is stored in
//   its own push step; each match byte is a window read, then write and pack, and a
//   full lane buffer is sent as a beat before the next byte is written.
//   in_chan.ready is high only while the sequencer is idle.
//   out_chan carries beats of up to 8 decoded bytes; valid_count gives the used
//   lanes, unused lanes read zero. run_end marks the last beat caused by an input
//   byte; stream_done or decode_error ride on that beat of the final byte. A byte
//   that yields nothing and is not final gives no beat.
//   A beat waits in the output register; when it is stalled and the lane buffer
//   fills again, the sequencer holds until the receiver takes the beat.
//   After the stream ends, further input beats are taken and dropped until reset.
//   Reset (rst, synchronous) clears control state, not the window RAM; bytes older
//   than the output start read as zero by a produced-byte count. The cfg port writes
//   text_mode (index 0), big_file (index 1); users must do so while idle; unchecked.
module implode_lz_tree_decoder_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic           cfg_data,
  ild_in_if.sink         in_chan,
  ild_out_if.source      out_chan
);

  localparam int AW = ild_pkg::HIST_AW;
  localparam int PW = ild_pkg::PROD_W;
  localparam int CW = ild_pkg::LANE_CW;
  localparam int MW = ild_pkg::MATCH_W;

  // configuration
  logic text_mode, big_file;

  // sequencer and token state
  ild_pkg::seq_t   state, state_next;
  ild_pkg::phase_t phase, phase_next;
  logic [15:0]     acc, acc_next;
  logic [4:0]      cnt, cnt_next;
  logic [6:0]      low_dist, low_dist_next;
  logic [5:0]      high_dist, high_dist_next;
  logic [MW-1:0]   mlen, mlen_next;
  logic [2:0]      bit_pos, bit_pos_next;
  logic [7:0]      in_byte, in_byte_next;
  logic            in_fin, in_fin_next;
  logic            tok_done, tok_done_next;
  logic            ended, ended_next;
  logic [MW-1:0]   remaining, remaining_next;
  logic            from_mem, from_mem_next;
  logic            zero_fill, zero_fill_next;
  logic [7:0]      lit_byte, lit_byte_next;
  logic [AW-1:0]   wp, wp_next;
  logic [PW-1:0]   produced, produced_next;

  // lane packing and output register
  logic [7:0]      lane_buf [ild_pkg::OUT_LANES];
  logic [CW-1:0]   buf_cnt, buf_cnt_next;
  logic            out_valid;
  logic [7:0]      out_lane [ild_pkg::OUT_LANES];
  logic [CW-1:0]   out_cnt;
  logic            out_end, out_done, out_err;
  logic            out_load, out_last, out_done_in, out_err_in;
  logic            slot_free;

  // window RAM port
  logic            mem_we, mem_re;
  logic [AW-1:0]   raddr;
  logic [7:0]      rdata;
  logic [7:0]      push_byte;

  // shared tree lookup
  ild_pkg::tree_id_t  tree_sel;
  ild_pkg::tree_res_t tree_res;
  logic [15:0]        code_q;
  logic [4:0]         code_n;

  logic            big_text;
  logic [2:0]      dbits;
  logic [MW-1:0]   minlen;
  logic [AW-1:0]   dist_raw;
  logic [PW-1:0]   match_dist;
  logic            cur_bit;
  logic [15:0]     raw_acc;
  ild_pkg::tree_id_t len_tree, dist_tree;

  assign big_text = text_mode & big_file;
  assign dbits    = big_text ? 3'd7 : 3'd6;
  assign minlen   = big_text ? MW'(3) : MW'(2);
  assign len_tree = text_mode ? (big_file ? ild_pkg::TREE_LEN_TXT_BIG
                                          : ild_pkg::TREE_LEN_TXT_SMALL)
                              : ild_pkg::TREE_LEN_BIN;
  assign dist_tree = text_mode ? (big_file ? ild_pkg::TREE_DIST_TXT_BIG
                                           : ild_pkg::TREE_DIST_TXT_SMALL)
                               : ild_pkg::TREE_DIST_BIN;

  // distance: raw low part below the tree-coded high part, plus one
  assign dist_raw   = big_text ? {high_dist, low_dist[6:0]}
                               : {1'b0, high_dist, low_dist[5:0]};
  assign match_dist = PW'(dist_raw) + PW'(1);

  assign cur_bit = in_byte[bit_pos];
  assign raw_acc = acc | (16'(cur_bit) << cnt[3:0]);
  assign code_q  = {acc[14:0], cur_bit};
  assign code_n  = cnt + 5'd1;

  always_comb begin
    unique case (phase)
      ild_pkg::PH_LIT_TREE: tree_sel = ild_pkg::TREE_LIT;
      ild_pkg::PH_HI_DIST:  tree_sel = dist_tree;
      default:              tree_sel = len_tree;
    endcase
  end

  ild_tree_rom u_tree (
    .tree_sel (tree_sel),
    .code     (code_q),
    .code_len (code_n),
    .res      (tree_res)
  );

  ild_history u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp),
    .wdata (push_byte),
    .re    (mem_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_chan.ready = (state == ild_pkg::S_IDLE);
  assign slot_free     = !out_valid || out_chan.ready;
  assign push_byte     = from_mem ? (zero_fill ? 8'd0 : rdata) : lit_byte;
  assign raddr         = wp - match_dist[AW-1:0];

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    acc_next       = acc;
    cnt_next       = cnt;
    low_dist_next  = low_dist;
    high_dist_next = high_dist;
    mlen_next      = mlen;
    bit_pos_next   = bit_pos;
    in_byte_next   = in_byte;
    in_fin_next    = in_fin;
    tok_done_next  = tok_done;
    ended_next     = ended;
    remaining_next = remaining;
    from_mem_next  = from_mem;
    zero_fill_next = zero_fill;
    lit_byte_next  = lit_byte;
    wp_next        = wp;
    produced_next  = produced;
    buf_cnt_next   = buf_cnt;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    out_load       = 1'b0;
    out_last       = 1'b0;
    out_done_in    = 1'b0;
    out_err_in     = 1'b0;

    unique case (state)
      ild_pkg::S_IDLE: begin
        // drop input after the stream has ended
        if (in_chan.valid && !ended) begin
          in_byte_next  = in_chan.packed_byte;
          in_fin_next   = in_chan.final_byte;
          bit_pos_next  = 3'd0;
          tok_done_next = 1'b0;
          state_next    = ild_pkg::S_BIT;
        end
      end

      ild_pkg::S_BIT: begin
        // default: advance to the next bit, or finish the byte
        if (bit_pos == 3'd7) begin
          state_next = ild_pkg::S_END;
        end else begin
          bit_pos_next = bit_pos + 3'd1;
        end
        unique case (phase)
          ild_pkg::PH_FLAG: begin
            acc_next   = 16'd0;
            cnt_next   = 5'd0;
            phase_next = cur_bit ? (big_text ? ild_pkg::PH_LIT_TREE : ild_pkg::PH_LIT_RAW)
                                 : ild_pkg::PH_LO_DIST;
          end
          ild_pkg::PH_LIT_RAW: begin
            acc_next = raw_acc;
            cnt_next = code_n;
            if (code_n == 5'd8) begin
              lit_byte_next  = raw_acc[7:0];
              acc_next       = 16'd0;
              cnt_next       = 5'd0;
              phase_next     = ild_pkg::PH_FLAG;
              from_mem_next  = 1'b0;
              remaining_next = '0;
              state_next     = ild_pkg::S_PUSH;
            end
          end
          ild_pkg::PH_LIT_TREE: begin
            acc_next = code_q;
            cnt_next = code_n;
            if (tree_res.hit) begin
              lit_byte_next  = tree_res.symbol;
              acc_next       = 16'd0;
              cnt_next       = 5'd0;
              phase_next     = ild_pkg::PH_FLAG;
              from_mem_next  = 1'b0;
              remaining_next = '0;
              state_next     = ild_pkg::S_PUSH;
            end
          end
          ild_pkg::PH_LO_DIST: begin
            acc_next = raw_acc;
            cnt_next = code_n;
            // a mode change between bytes may shorten the field below the bits taken
            if (code_n >= {2'd0, dbits}) begin
              low_dist_next = raw_acc[6:0];
              acc_next      = 16'd0;
              cnt_next      = 5'd0;
              phase_next    = ild_pkg::PH_HI_DIST;
            end
          end
          ild_pkg::PH_HI_DIST: begin
            acc_next = code_q;
            cnt_next = code_n;
            if (tree_res.hit) begin
              high_dist_next = tree_res.symbol[5:0];
              acc_next       = 16'd0;
              cnt_next       = 5'd0;
              phase_next     = ild_pkg::PH_LEN;
            end
          end
          ild_pkg::PH_LEN: begin
            acc_next = code_q;
            cnt_next = code_n;
            if (tree_res.hit) begin
              acc_next  = 16'd0;
              cnt_next  = 5'd0;
              mlen_next = MW'(tree_res.symbol[5:0]);
              if (tree_res.symbol[5:0] == ild_pkg::LEN_ESCAPE) begin
                phase_next = ild_pkg::PH_LEN_EXT;
              end else begin
                phase_next     = ild_pkg::PH_FLAG;
                remaining_next = MW'(tree_res.symbol[5:0]) + minlen;
                state_next     = ild_pkg::S_CP_RD;
              end
            end
          end
          ild_pkg::PH_LEN_EXT: begin
            acc_next = raw_acc;
            cnt_next = code_n;
            if (code_n == 5'd8) begin
              mlen_next      = MW'(ild_pkg::LEN_ESCAPE) + MW'(raw_acc[7:0]);
              acc_next       = 16'd0;
              cnt_next       = 5'd0;
              phase_next     = ild_pkg::PH_FLAG;
              remaining_next = MW'(ild_pkg::LEN_ESCAPE) + MW'(raw_acc[7:0]) + minlen;
              state_next     = ild_pkg::S_CP_RD;
            end
          end
          default: begin
            phase_next = ild_pkg::PH_FLAG;
          end
        endcase
        // a token that completes keeps the bit position until its bytes are stored
        if (state_next == ild_pkg::S_PUSH || state_next == ild_pkg::S_CP_RD) begin
          bit_pos_next = bit_pos;
        end
      end

      ild_pkg::S_CP_RD: begin
        // fetch one match byte; bytes before the output start read as zero
        mem_re         = 1'b1;
        zero_fill_next = (produced < match_dist);
        from_mem_next  = 1'b1;
        state_next     = ild_pkg::S_PUSH;
      end

      ild_pkg::S_PUSH: begin
        if (buf_cnt == CW'(ild_pkg::OUT_LANES)) begin
          // lane buffer full: send it as a non-final beat first
          if (slot_free) begin
            out_load     = 1'b1;
            buf_cnt_next = '0;
          end
        end else begin
          mem_we       = 1'b1;
          buf_cnt_next = buf_cnt + CW'(1);
          wp_next      = wp + AW'(1);
          if (produced != PW'(ild_pkg::WINDOW_DEPTH)) begin
            produced_next = produced + PW'(1);
          end
          if (from_mem && (remaining != MW'(1))) begin
            remaining_next = remaining - MW'(1);
            state_next     = ild_pkg::S_CP_RD;
          end else begin
            remaining_next = '0;
            // token finished
            if (in_fin) begin
              tok_done_next = 1'b1;
              state_next    = ild_pkg::S_END;
            end else if (bit_pos == 3'd7) begin
              state_next = ild_pkg::S_END;
            end else begin
              bit_pos_next = bit_pos + 3'd1;
              state_next   = ild_pkg::S_BIT;
            end
          end
        end
      end

      ild_pkg::S_END: begin
        if (in_fin || (buf_cnt != '0)) begin
          if (slot_free) begin
            out_load     = 1'b1;
            out_last     = 1'b1;
            out_done_in  = in_fin && tok_done;
            out_err_in   = in_fin && !tok_done;
            buf_cnt_next = '0;
            ended_next   = in_fin;
            state_next   = ild_pkg::S_IDLE;
          end
        end else begin
          state_next = ild_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ild_pkg::S_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      text_mode <= 1'b0;
      big_file  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ild_pkg::CFG_TEXT_MODE: text_mode <= cfg_data;
        ild_pkg::CFG_BIG_FILE:  big_file  <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ild_pkg::S_IDLE;
      phase     <= ild_pkg::PH_FLAG;
      acc       <= 16'd0;
      cnt       <= 5'd0;
      low_dist  <= 7'd0;
      high_dist <= 6'd0;
      mlen      <= '0;
      bit_pos   <= 3'd0;
      in_fin    <= 1'b0;
      tok_done  <= 1'b0;
      ended     <= 1'b0;
      remaining <= '0;
      from_mem  <= 1'b0;
      wp        <= '0;
      produced  <= '0;
      buf_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      acc       <= acc_next;
      cnt       <= cnt_next;
      low_dist  <= low_dist_next;
      high_dist <= high_dist_next;
      mlen      <= mlen_next;
      bit_pos   <= bit_pos_next;
      in_fin    <= in_fin_next;
      tok_done  <= tok_done_next;
      ended     <= ended_next;
      remaining <= remaining_next;
      from_mem  <= from_mem_next;
      wp        <= wp_next;
      produced  <= produced_next;
      buf_cnt   <= buf_cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_byte   <= in_byte_next;
    lit_byte  <= lit_byte_next;
    zero_fill <= zero_fill_next;
    if (mem_we) begin
      lane_buf[buf_cnt[CW-2:0]] <= push_byte;
    end
    if (out_load) begin
      for (int j = 0; j < ild_pkg::OUT_LANES; j++) begin
        out_lane[j] <= (CW'(j) < buf_cnt) ? lane_buf[j] : 8'd0;
      end
      out_cnt  <= buf_cnt;
      out_end  <= out_last;
      out_done <= out_done_in;
      out_err  <= out_err_in;
    end
  end

  assign out_chan.valid        = out_valid;
  assign out_chan.lane_0       = out_lane[0];
  assign out_chan.lane_1       = out_lane[1];
  assign out_chan.lane_2       = out_lane[2];
  assign out_chan.lane_3       = out_lane[3];
  assign out_chan.lane_4       = out_lane[4];
  assign out_chan.lane_5       = out_lane[5];
  assign out_chan.lane_6       = out_lane[6];
  assign out_chan.lane_7       = out_lane[7];
  assign out_chan.valid_count  = out_cnt;
  assign out_chan.run_end      = out_end;
  assign out_chan.stream_done  = out_done;
  assign out_chan.decode_error = out_err;

`ifndef ASSERT_OFF
  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |-> slot_free)
    else $error("beat loaded over a waiting beat");

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    buf_cnt <= CW'(ild_pkg::OUT_LANES))
    else $error("lane buffer overfilled");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_last) |=> (state == ild_pkg::S_IDLE))
    else $error("final beat did not return sequencer to idle");

  a_copy_has_len: assert property (@(posedge clk) disable iff (rst)
    (state == ild_pkg::S_CP_RD) |-> (remaining != '0))
    else $error("match copy with no bytes left");

  a_ended_silent: assert property (@(posedge clk) disable iff (rst)
    (ended && state == ild_pkg::S_IDLE) |=> (state == ild_pkg::S_IDLE))
    else $error("input decoded after end of stream");
`endif

endmodule
